// ----- rtl/core/gsa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Gear shift actuator package
// Shared types, codes and reset values for the gear actuator controller.
// ----------------------------------------------------------------------------
package gsa_pkg;

  // Timer width default and the fixed configuration register width
  localparam int unsigned TimerWidthDef = 16;
  localparam int unsigned CfgDataW      = 16;
  localparam int unsigned CfgIdxW       = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SETTLE  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 1'd1;

  localparam logic [CfgDataW-1:0] SettleRst  = 16'd100;
  localparam logic [CfgDataW-1:0] TimeoutRst = 16'd1000;

  // Event codes carried on the input tuser
  localparam logic [1:0] FUNC_SHIFT = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Gear positions
  localparam logic [1:0] GEAR_P = 2'd0;
  localparam logic [1:0] GEAR_R = 2'd1;
  localparam logic [1:0] GEAR_N = 2'd2;
  localparam logic [1:0] GEAR_D = 2'd3;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_SHIFTING = 2'd1,
    MODE_FAULT    = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] requested_gear;
  } item_t;

  typedef struct packed {
    logic       fault_code;
    logic       is_shifting;
    logic [1:0] gear_now;
    logic       drive_bit1;
    logic       drive_bit0;
    logic       request_status;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/gsa_in_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Gear shift actuator input stage
// Registers one incoming word and holds it until the control stage takes it.
// ----------------------------------------------------------------------------
module gsa_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire gsa_pkg::item_t in_item_i,
  output logic                item_valid_o,
  input  wire logic           item_take_i,
  output gsa_pkg::item_t      item_o
);
  import gsa_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload loads on every accepted word
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

// ----- rtl/core/gsa_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Gear shift actuator control
// Mode state machine, shift timer and configuration registers.
// ----------------------------------------------------------------------------
module gsa_ctrl #(
  parameter int unsigned TIMER_WIDTH = gsa_pkg::TimerWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [gsa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [gsa_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                          step_i,
  input  wire gsa_pkg::item_t                item_i,
  output gsa_pkg::result_t                   result_o
);
  import gsa_pkg::*;

  localparam int unsigned CmpW = (TIMER_WIDTH > CfgDataW) ? TIMER_WIDTH : CfgDataW;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = {TIMER_WIDTH{1'b1}};

  logic [CfgDataW-1:0]    settle_q, timeout_q;
  mode_e                  mode_q, mode_d;
  logic [1:0]             confirmed_q, confirmed_d;
  logic [1:0]             target_q, target_d;
  logic [TIMER_WIDTH-1:0] timer_q, timer_d, timer_inc;
  logic [1:0]             drive_q, drive_d;
  logic                   fault_q, fault_d;
  logic                   refused;
  logic [CmpW-1:0]        timer_cmp, settle_cmp, timeout_cmp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q  <= SettleRst;
      timeout_q <= TimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SETTLE:  settle_q  <= cfg_wdata_i;
        CFG_TIMEOUT: timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Saturating increment, compared after the bump
  assign timer_inc   = (timer_q == TimerMax) ? timer_q : timer_q + 1'b1;
  assign timer_cmp   = CmpW'(timer_inc);
  assign settle_cmp  = CmpW'(settle_q);
  assign timeout_cmp = CmpW'(timeout_q);

  // Next state
  always_comb begin
    mode_d      = mode_q;
    confirmed_d = confirmed_q;
    target_d    = target_q;
    timer_d     = timer_q;
    drive_d     = drive_q;
    fault_d     = fault_q;
    refused     = 1'b0;
    case (item_i.func)
      FUNC_SHIFT: begin
        if (mode_q == MODE_SHIFTING || mode_q == MODE_FAULT) begin
          refused = 1'b1;
        end else if (item_i.requested_gear != confirmed_q) begin
          target_d = item_i.requested_gear;
          mode_d   = MODE_SHIFTING;
          timer_d  = '0;
          drive_d  = item_i.requested_gear;
        end
      end
      FUNC_TICK: begin
        if (mode_q == MODE_SHIFTING) begin
          timer_d = timer_inc;
          if (timer_cmp > timeout_cmp) begin
            mode_d  = MODE_FAULT;
            fault_d = 1'b1;
          end else if (timer_cmp > settle_cmp) begin
            confirmed_d = target_q;
            mode_d      = MODE_IDLE;
          end
        end
      end
      FUNC_CLEAR: begin
        // force park, timer left as it is
        mode_d      = MODE_IDLE;
        confirmed_d = GEAR_P;
        target_d    = GEAR_P;
        drive_d     = GEAR_P;
        fault_d     = 1'b0;
      end
      default: ;
    endcase
  end

  // Result shows the state after the event
  always_comb begin
    result_o.request_status = refused;
    result_o.drive_bit0     = drive_d[0];
    result_o.drive_bit1     = drive_d[1];
    result_o.gear_now       = confirmed_d;
    result_o.is_shifting    = (mode_d == MODE_SHIFTING);
    result_o.fault_code     = fault_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      confirmed_q <= GEAR_P;
      target_q    <= GEAR_P;
      timer_q     <= '0;
      drive_q     <= GEAR_P;
      fault_q     <= 1'b0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      confirmed_q <= confirmed_d;
      target_q    <= target_d;
      timer_q     <= timer_d;
      drive_q     <= drive_d;
      fault_q     <= fault_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/gsa_out_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Gear shift actuator output stage
// Result register that holds a word until the downstream side takes it.
// ----------------------------------------------------------------------------
module gsa_out_stage (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             res_valid_i,
  output logic                                  res_ready_o,
  input  wire gsa_pkg::result_t                 res_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [gsa_pkg::OutDataW-1:0]          out_data_o
);
  import gsa_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign res_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = OutDataW'(res_q);

endmodule
`default_nettype wire

// ----- rtl/core/gear_shift_actuator_fsm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Gear shift actuator controller
// Four-position (P R N D) actuator control with idle, shifting and fault modes.
// ----------------------------------------------------------------------------
//  Channel   Dir  Contents
//  s_axis    in   tuser: func; tdata: requested_gear
//  m_axis    out  tdata: status, drive lines, gear, shifting, fault
//  cfg       in   write enable, index, 16-bit data (settle, timeout)
//
//  One word per cycle sustained while m_axis accepts; from input acceptance the
//  word passes through the input register and then the result register.
//  Reset clears mode, gears, timer, drive and fault; settle is 100, timeout 1000.
//  A stalled m_axis holds its word and backs up into the input register.
// ----------------------------------------------------------------------------
module gear_shift_actuator_fsm #(
  parameter int unsigned TIMER_WIDTH = gsa_pkg::TimerWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] requested_gear, [7:2] zero
  input  wire logic [gsa_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] func
  input  wire logic [1:0]                    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [0] request_status, [1] drive_bit0, [2] drive_bit1, [4:3] gear_now,
  // [5] is_shifting, [6] fault_code, [7] zero
  output logic [gsa_pkg::OutDataW-1:0]       m_axis_tdata,
  input  wire logic                          cfg_we_i,
  input  wire logic [gsa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [gsa_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import gsa_pkg::*;

  item_t   in_item, item;
  result_t res;
  logic    item_valid, res_ready, step;

  assign in_item.func           = s_axis_tuser;
  assign in_item.requested_gear = s_axis_tdata[1:0];

  gsa_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_take_i  (res_ready),
    .item_o       (item)
  );

  // advance the state only when the word moves into the result register
  assign step = item_valid && res_ready;

  gsa_ctrl #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (item),
    .result_o    (res)
  );

  gsa_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (item_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

// ----- bench/gear_shift_actuator_fsm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gear shift actuator checker
// Watches the input, output and register channels of the actuator controller,
// runs its own model of the mode, gear, timer and drive state for every word
// accepted on the input, and compares every output word field by field.
// ----------------------------------------------------------------------------
module gear_shift_actuator_fsm_checker #(
  parameter int unsigned TIMER_WIDTH = gsa_pkg::TimerWidthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  input  wire logic                         s_axis_tready,
  // [1:0] requested_gear, [7:2] zero
  input  wire logic [gsa_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] func
  input  wire logic [1:0]                   s_axis_tuser,
  input  wire logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [0] request_status, [1] drive_bit0, [2] drive_bit1, [4:3] gear_now,
  // [5] is_shifting, [6] fault_code, [7] zero
  input  wire logic [gsa_pkg::OutDataW-1:0] m_axis_tdata,
  input  wire logic                         cfg_we_i,
  input  wire logic [gsa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [gsa_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int unsigned                       mismatch_cnt_o,
  output int unsigned                       pending_o
);
  import gsa_pkg::*;

  // Status words still owed by the controller, oldest first
  result_t status_words_q[$];

  mode_e                  mode_q;
  logic [1:0]             gear_q;
  logic [1:0]             target_q;
  logic [1:0]             drive_q;
  logic                   fault_q;
  logic [TIMER_WIDTH-1:0] timer_q;
  logic [CfgDataW-1:0]    settle_q;
  logic [CfgDataW-1:0]    timeout_q;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: status word mismatch on %s: got %0h, want %0h",
             $time, what, got, want);
    mismatch_cnt_o++;
  endtask

  // Apply one event to the modelled controller and return its status word
  task automatic advance_actuator(input item_t ev, output result_t word);
    logic refused;
    refused = 1'b0;
    case (ev.func)
      FUNC_SHIFT: begin
        if (mode_q != MODE_IDLE) begin
          refused = 1'b1;
        end else if (ev.requested_gear != gear_q) begin
          target_q = ev.requested_gear;
          mode_q   = MODE_SHIFTING;
          timer_q  = '0;
          drive_q  = ev.requested_gear;
        end
      end
      FUNC_TICK: begin
        if (mode_q == MODE_SHIFTING) begin
          // saturate rather than wrap
          if (timer_q != '1) timer_q = timer_q + 1'b1;
          if (64'(timer_q) > 64'(timeout_q)) begin
            mode_q  = MODE_FAULT;
            fault_q = 1'b1;
          end else if (64'(timer_q) > 64'(settle_q)) begin
            gear_q = target_q;
            mode_q = MODE_IDLE;
          end
        end
      end
      FUNC_CLEAR: begin
        // timer is left alone
        drive_q  = GEAR_P;
        mode_q   = MODE_IDLE;
        fault_q  = 1'b0;
        gear_q   = GEAR_P;
        target_q = GEAR_P;
      end
      default: ;
    endcase
    word.request_status = refused;
    word.drive_bit0     = drive_q[0];
    word.drive_bit1     = drive_q[1];
    word.gear_now       = gear_q;
    word.is_shifting    = (mode_q == MODE_SHIFTING);
    word.fault_code     = fault_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    item_t   ev;
    result_t want;
    result_t got;
    if (!rst_ni) begin
      mode_q         = MODE_IDLE;
      gear_q         = GEAR_P;
      target_q       = GEAR_P;
      drive_q        = GEAR_P;
      fault_q        = 1'b0;
      timer_q        = '0;
      settle_q       = SettleRst;
      timeout_q      = TimeoutRst;
      mismatch_cnt_o = 0;
      status_words_q.delete();
      pending_o      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SETTLE:  settle_q  = cfg_wdata_i;
          CFG_TIMEOUT: timeout_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        ev.func           = s_axis_tuser;
        ev.requested_gear = s_axis_tdata[1:0];
        advance_actuator(ev, want);
        status_words_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_words_q.size() == 0) begin
          report_mismatch("unexpected word", 32'(m_axis_tdata), 32'd0);
        end else begin
          want = status_words_q.pop_front();
          got  = result_t'(m_axis_tdata[6:0]);
          if (got.request_status !== want.request_status)
            report_mismatch("request_status", 32'(got.request_status),
                            32'(want.request_status));
          if (got.drive_bit0 !== want.drive_bit0)
            report_mismatch("drive_bit0", 32'(got.drive_bit0), 32'(want.drive_bit0));
          if (got.drive_bit1 !== want.drive_bit1)
            report_mismatch("drive_bit1", 32'(got.drive_bit1), 32'(want.drive_bit1));
          if (got.gear_now !== want.gear_now)
            report_mismatch("gear_now", 32'(got.gear_now), 32'(want.gear_now));
          if (got.is_shifting !== want.is_shifting)
            report_mismatch("is_shifting", 32'(got.is_shifting), 32'(want.is_shifting));
          if (got.fault_code !== want.fault_code)
            report_mismatch("fault_code", 32'(got.fault_code), 32'(want.fault_code));
          if (m_axis_tdata[7] !== 1'b0)
            report_mismatch("pad bit", 32'(m_axis_tdata[7]), 32'd0);
        end
      end
      pending_o = status_words_q.size();
    end
  end

endmodule

// ----- bench/gear_shift_actuator_fsm_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gear shift actuator testbench
// Drives shift requests, ticks and fault clears into the controller under
// several settle and timeout settings, with random gaps and stalls on both
// streams and one long output hold-off; the checker scores every word.
// ----------------------------------------------------------------------------
module gear_shift_actuator_fsm_tb;
  import gsa_pkg::*;

  localparam int unsigned TimerW      = TimerWidthDef;
  localparam logic [1:0]  FuncSpare   = 2'd3;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 2000000;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned cycle_cnt;
  bit          quiet;
  bit          hold_pending;

  gear_shift_actuator_fsm #(
    .TIMER_WIDTH (TimerW)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  gear_shift_actuator_fsm_checker #(
    .TIMER_WIDTH (TimerW)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[gear_shift_actuator_fsm] ERROR");
    $finish;
  end

  // Output side: random stalls, mostly short, plus one long hold-off on request
  initial begin : drive_receiver
    int unsigned stall_left;
    int unsigned pick;
    stall_left    = 0;
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall_left   = HoldCycles;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (quiet) begin
        m_axis_tready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          m_axis_tready <= 1'b1;
        end else begin
          stall_left    = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
          m_axis_tready <= 1'b0;
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Offer one word and hold it until the controller takes it
  task automatic send_word(input logic [1:0] func, input logic [1:0] gear);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {6'b0, gear};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_timing(input logic [CfgDataW-1:0] settle,
                              input logic [CfgDataW-1:0] timeout);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SETTLE;
    cfg_wdata_i <= settle;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_TIMEOUT;
    cfg_wdata_i <= timeout;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Shift then tick around the point where it settles or faults, with noise
  task automatic run_shift_phase(input logic [CfgDataW-1:0] settle,
                                 input logic [CfgDataW-1:0] timeout,
                                 input int unsigned count);
    int unsigned sent;
    int unsigned thr;
    int unsigned ticks;
    int unsigned pick;
    write_timing(settle, timeout);
    sent = 0;
    thr  = ((settle < timeout) ? settle : timeout) + 1;
    if (thr > 150) thr = 150;
    while (sent < count) begin
      quiet = ($urandom_range(0, 7) == 0);
      send_word(FUNC_SHIFT, 2'($urandom_range(0, 3)));
      sent++;
      if ($urandom_range(0, 1) == 0) begin
        ticks = (thr == 0 ? 0 : thr - 1) + $urandom_range(0, 3);
      end else begin
        ticks = $urandom_range(0, thr + 2);
      end
      repeat (ticks) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        end else begin
          send_word(FUNC_TICK, 2'($urandom_range(0, 3)));
        end
        sent++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_word(FUNC_CLEAR, 2'($urandom_range(0, 3)));
        sent++;
      end else if (pick < 35) begin
        send_word(FuncSpare, 2'($urandom_range(0, 3)));
        sent++;
      end
    end
    quiet = 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_SHIFT;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_SETTLE;
    cfg_wdata_i   = '0;
    quiet         = 1'b0;
    hold_pending  = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: confirm paths, refusal while shifting, clear mid-shift
    write_timing(16'd1, 16'd3);
    send_word(FuncSpare, GEAR_D);
    send_word(FUNC_TICK, GEAR_P);
    send_word(FUNC_SHIFT, GEAR_P);
    send_word(FUNC_SHIFT, GEAR_R);
    send_word(FUNC_SHIFT, GEAR_N);
    send_word(FuncSpare, GEAR_N);
    send_word(FUNC_TICK, GEAR_P);
    send_word(FUNC_TICK, GEAR_D);
    send_word(FUNC_SHIFT, GEAR_R);
    send_word(FUNC_SHIFT, GEAR_D);
    send_word(FUNC_CLEAR, GEAR_D);
    send_word(FUNC_SHIFT, GEAR_N);
    send_word(FUNC_TICK, GEAR_N);
    send_word(FUNC_TICK, GEAR_R);
    wait_drained();

    // Directed: zero limits fault on the first tick; refusal and clear in fault
    write_timing(16'd0, 16'd0);
    send_word(FUNC_SHIFT, GEAR_D);
    send_word(FUNC_TICK, GEAR_P);
    send_word(FUNC_SHIFT, GEAR_P);
    send_word(FUNC_TICK, GEAR_P);
    send_word(FuncSpare, GEAR_R);
    send_word(FUNC_CLEAR, GEAR_P);
    send_word(FUNC_CLEAR, GEAR_N);
    wait_drained();

    // Widest limits: a few ticks neither settle nor fault the shift
    write_timing(16'hFFFF, 16'hFFFE);
    quiet = 1'b1;
    send_word(FUNC_SHIFT, GEAR_R);
    repeat (8) send_word(FUNC_TICK, GEAR_D);
    send_word(FUNC_SHIFT, GEAR_N);
    send_word(FUNC_CLEAR, GEAR_R);
    quiet = 1'b0;
    wait_drained();

    // Random phases; the first one starts with a long output hold-off
    hold_pending = 1'b1;
    run_shift_phase(SettleRst, TimeoutRst, 320);
    run_shift_phase(16'd0, 16'd0, 120);
    run_shift_phase(16'd5, 16'd2, 150);
    run_shift_phase(16'd2, 16'd9, 200);
    run_shift_phase(16'hFFFF, 16'd0, 80);
    run_shift_phase(16'd0, 16'hFFFE, 80);
    run_shift_phase(16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)), 300);

    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("[gear_shift_actuator_fsm] OK");
    end else begin
      $display("[gear_shift_actuator_fsm] ERROR");
    end
    $finish;
  end

endmodule
